// ===== hdl/smsd_pkg.sv =====
// shared constants, types and helpers of the sliding median spike detector
// depends on nothing; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package smsd_pkg;

   // defaults of the top level parameters
   localparam int unsigned MAX_WINDOW_DEFAULT   = 32;
   localparam int unsigned SAMPLE_WIDTH_DEFAULT = 16;

   // window_length register
   localparam int unsigned WL_W         = 6;
   localparam logic [5:0]  WINDOW_RESET = 6'd5;

   // running alert count
   localparam int unsigned COUNT_W = 16;

   // csr port
   localparam int unsigned APB_DATA_W = 32;
   localparam int unsigned APB_ADDR_W = 3;
   // register index taken from paddr[APB_ADDR_W-1:2]
   localparam logic        REG_WINDOW_LENGTH = 1'b0;

   // control broadcast to every sorting cell
   typedef struct packed {
      logic clear;   // empty all cells
      logic insert;  // insert the broadcast value
   } sort_ctl_type;

   // flags a cell hands to its right neighbor
   typedef struct packed {
      logic occ;     // cell holds a value
      logic ins;     // broadcast value lands at or left of this cell
   } link_type;

   // pointer width for a ring of the given depth, never zero
   function automatic int unsigned ptr_width(input int unsigned depth);
      int unsigned w;
      w = 1;
      if (depth > 1) begin
         w = $clog2(depth);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/smsd_cell.sv =====
// one cell of the sorted insertion chain
// depends on smsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module smsd_cell #(
   parameter int unsigned SAMPLE_WIDTH = smsd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire smsd_pkg::sort_ctl_type  ctl,
   input  wire logic [SAMPLE_WIDTH-1:0] new_value,
   input  wire logic [SAMPLE_WIDTH-1:0] left_value,
   input  wire smsd_pkg::link_type      left_link,
   output logic      [SAMPLE_WIDTH-1:0] value,
   output smsd_pkg::link_type           link
);

   logic [SAMPLE_WIDTH-1:0] value_ff;
   logic [SAMPLE_WIDTH-1:0] value_in;
   logic                    occ_ff;
   logic                    occ_in;
   logic                    ins;

   // empty cells count as larger than anything
   assign ins = !occ_ff || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctl.clear) begin
         occ_in = 1'b0;
      end else if (ctl.insert && ins) begin
         if (left_link.ins) begin
            // shift right to open the slot
            value_in = left_value;
            occ_in   = left_link.occ;
         end else begin
            value_in = new_value;
            occ_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign link.occ = occ_ff;
   assign link.ins = ins;

endmodule

`default_nettype wire

// ===== hdl/smsd_sort_chain.sv =====
// row of sorting cells kept in ascending order by broadcast insertion
// depends on smsd_pkg and smsd_cell
`timescale 1ns / 1ps
`default_nettype none

module smsd_sort_chain #(
   parameter int unsigned MAX_WINDOW   = smsd_pkg::MAX_WINDOW_DEFAULT,
   parameter int unsigned SAMPLE_WIDTH = smsd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire smsd_pkg::sort_ctl_type                 ctl,
   input  wire logic [SAMPLE_WIDTH-1:0]                new_value,
   output logic      [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] cell_values
);

   smsd_pkg::link_type links [MAX_WINDOW];

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [SAMPLE_WIDTH-1:0] left_value;
      smsd_pkg::link_type      left_link;

      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_link  = '0;
      end else begin : g_body
         assign left_value = cell_values[i-1];
         assign left_link  = links[i-1];
      end

      smsd_cell #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_value (new_value),
         .left_value(left_value),
         .left_link (left_link),
         .value     (cell_values[i]),
         .link      (links[i])
      );
   end

endmodule

`default_nettype wire

// ===== hdl/smsd_history.sv =====
// sample history ring: one write port, one registered read port
// depends on smsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module smsd_history #(
   parameter  int unsigned MAX_WINDOW   = smsd_pkg::MAX_WINDOW_DEFAULT,
   parameter  int unsigned SAMPLE_WIDTH = smsd_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int unsigned PTR_W        = smsd_pkg::ptr_width(MAX_WINDOW)
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [PTR_W-1:0]        wr_addr,
   input  wire logic [SAMPLE_WIDTH-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [PTR_W-1:0]        rd_addr,
   output logic      [SAMPLE_WIDTH-1:0] rd_data
);

   logic [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/sliding_median_spike_detector_core.sv =====
// top level of the sliding median spike detector
// depends on smsd_pkg, smsd_history, smsd_sort_chain and smsd_cell
`timescale 1ns / 1ps
`default_nettype none

// Each req beat carries one unsigned sample. Once window_length earlier samples
// have been seen, the sample is flagged when it is at least twice the median of
// those samples (for an even window: at least the sum of the two middle values),
// and a saturating 16-bit count of flags is kept. Every req beat yields exactly
// one rsp beat. Items are worked one at a time. For a sample that finds a full
// window, len being the effective window length, the history memory's single read
// port streams the len most recent samples, one per cycle, into a chain of sorting
// cells; then the last read is inserted, the load phase ends once the read pipe is
// empty, the middle cells are picked, the result is formed and the sequencer returns
// to idle. A sample that arrives before the window is full skips the load and
// select phases. A
// finished result sits in the rsp register, so the next sample is accepted and
// worked while it waits; only delivering the following result waits on rsp_stall.
// window_length 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW, and a new
// length keeps the history and counts from the next sample. No clearing pass is
// needed after reset.

module sliding_median_spike_detector_core #(
   parameter int unsigned MAX_WINDOW   = smsd_pkg::MAX_WINDOW_DEFAULT,
   parameter int unsigned SAMPLE_WIDTH = smsd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // sample channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0]         req_sample,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_window_full,
   output logic                                 rsp_alert,
   output logic [smsd_pkg::COUNT_W-1:0]         rsp_alert_count,
   // csr port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [smsd_pkg::APB_ADDR_W-1:0] paddr,
   input  wire logic [smsd_pkg::APB_DATA_W-1:0] pwdata,
   output logic      [smsd_pkg::APB_DATA_W-1:0] prdata,
   output logic                                 pready
);

   localparam int unsigned PTR_W   = smsd_pkg::ptr_width(MAX_WINDOW);
   localparam int unsigned LEN_W   = $clog2(MAX_WINDOW + 1);
   localparam int unsigned WL_W    = smsd_pkg::WL_W;
   localparam int unsigned CMP_W   = (LEN_W > WL_W) ? LEN_W : WL_W;
   localparam int unsigned COUNT_W = smsd_pkg::COUNT_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;  // waiting for a sample
   localparam logic [1:0] ST_LOAD   = 2'd1;  // streaming history into the chain
   localparam logic [1:0] ST_SELECT = 2'd2;  // latching the middle cells
   localparam logic [1:0] ST_FINISH = 2'd3;  // compare, write history, hand off

   // ---------------------------------------------------------------- csr
   logic [WL_W-1:0] window_length_ff;
   logic            csr_hit;

   assign csr_hit = (paddr[smsd_pkg::APB_ADDR_W-1:2] == smsd_pkg::REG_WINDOW_LENGTH);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= smsd_pkg::WINDOW_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         window_length_ff <= pwdata[WL_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = {{(smsd_pkg::APB_DATA_W - WL_W){1'b0}}, window_length_ff};
      end
   end

   // ---------------------------------------------------------------- state
   logic [1:0]              state_ff;
   logic [1:0]              state_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic [LEN_W-1:0]        len_ff;
   logic                    full_ff;
   logic [PTR_W-1:0]        wp_ff;
   logic [PTR_W-1:0]        rd_addr_ff;
   logic [LEN_W-1:0]        issue_cnt_ff;
   logic                    dv_ff;
   logic [LEN_W-1:0]        filled_ff;
   logic [SAMPLE_WIDTH-1:0] lo_ff;
   logic [SAMPLE_WIDTH-1:0] hi_ff;
   logic [COUNT_W-1:0]      alert_total_ff;
   logic [COUNT_W-1:0]      alert_total_in;
   logic                    rsp_valid_ff;
   logic                    rsp_full_ff;
   logic                    rsp_alert_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   // ---------------------------------------------------------------- window length
   logic [CMP_W-1:0] wl_ext;
   logic [LEN_W-1:0] len_eff;
   logic             full_now;

   assign wl_ext = CMP_W'(window_length_ff);

   always_comb begin
      if (wl_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         len_eff = LEN_W'(MAX_WINDOW);
      end else begin
         len_eff = LEN_W'(window_length_ff);
      end
   end

   assign full_now = (filled_ff >= len_eff);

   // ---------------------------------------------------------------- handshake
   logic accept;
   logic out_free;
   logic finish;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // rsp register can take the next result
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_FINISH) && out_free;

   // ---------------------------------------------------------------- history reads
   logic                    issue;
   logic [PTR_W-1:0]        wp_prev;
   logic [PTR_W-1:0]        rd_addr_dec;
   logic [SAMPLE_WIDTH-1:0] rd_data;

   // newest sample sits just behind the write pointer, walk backward from there
   assign wp_prev     = (wp_ff == '0) ? PTR_W'(MAX_WINDOW - 1) : wp_ff - PTR_W'(1);
   assign rd_addr_dec = (rd_addr_ff == '0) ? PTR_W'(MAX_WINDOW - 1)
                                           : rd_addr_ff - PTR_W'(1);
   assign issue       = (state_ff == ST_LOAD) && (issue_cnt_ff != len_ff);

   smsd_history #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_history (
      .clock  (clock),
      .wr_en  (finish),
      .wr_addr(wp_ff),
      .wr_data(sample_ff),
      .rd_en  (issue),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   // ---------------------------------------------------------------- sorting chain
   smsd_pkg::sort_ctl_type                  sort_ctl;
   logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] cell_values;

   // a new sample empties the chain; each returning read is inserted
   assign sort_ctl.clear  = accept;
   assign sort_ctl.insert = dv_ff;

   smsd_sort_chain #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_sort_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sort_ctl),
      .new_value  (rd_data),
      .cell_values(cell_values)
   );

   // ---------------------------------------------------------------- median pick
   logic [LEN_W-1:0] mid;
   logic [LEN_W-1:0] lo_pos;
   logic [PTR_W-1:0] lo_idx;
   logic [PTR_W-1:0] hi_idx;

   assign mid    = len_ff >> 1;
   // odd window: both taps on the middle cell, so the sum is twice the median
   assign lo_pos = len_ff[0] ? mid : mid - LEN_W'(1);
   assign lo_idx = PTR_W'(lo_pos);
   assign hi_idx = PTR_W'(mid);

   // ---------------------------------------------------------------- verdict
   logic [SAMPLE_WIDTH:0] ref_sum;
   logic                  alert_now;

   assign ref_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign alert_now = full_ff && ({1'b0, sample_ff} >= ref_sum);

   always_comb begin
      alert_total_in = alert_total_ff;
      if (alert_now && (alert_total_ff != {COUNT_W{1'b1}})) begin
         alert_total_in = alert_total_ff + COUNT_W'(1);
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = full_now ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            // all reads issued and the last one inserted
            if (!issue && !dv_ff) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         dv_ff          <= 1'b0;
         wp_ff          <= '0;
         filled_ff      <= '0;
         alert_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= issue;
         if (finish) begin
            wp_ff          <= (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
            alert_total_ff <= alert_total_in;
            if (filled_ff != LEN_W'(MAX_WINDOW)) begin
               filled_ff <= filled_ff + LEN_W'(1);
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff    <= req_sample;
         len_ff       <= len_eff;
         full_ff      <= full_now;
         rd_addr_ff   <= wp_prev;
         issue_cnt_ff <= '0;
      end else if (issue) begin
         rd_addr_ff   <= rd_addr_dec;
         issue_cnt_ff <= issue_cnt_ff + LEN_W'(1);
      end
      if (state_ff == ST_SELECT) begin
         lo_ff <= cell_values[lo_idx];
         hi_ff <= cell_values[hi_idx];
      end
      if (finish) begin
         rsp_full_ff  <= full_ff;
         rsp_alert_ff <= alert_now;
         rsp_count_ff <= alert_total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_full = rsp_full_ff;
   assign rsp_alert       = rsp_alert_ff;
   assign rsp_alert_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== hdl/smsd_checker.sv =====
// port-level checks of the sliding median spike detector, bound to the top level
// depends on smsd_pkg and sliding_median_spike_detector_core
`timescale 1ns / 1ps
`default_nettype none

module smsd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_window_full,
   input wire logic                         rsp_alert,
   input wire logic [smsd_pkg::COUNT_W-1:0] rsp_alert_count
);

   localparam int unsigned COUNT_W = smsd_pkg::COUNT_W;

   // count carried by the last delivered beat
   logic [COUNT_W-1:0] last_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_count_ff <= rsp_alert_count;
      end
   end

   // one sample at a time: an accept closes the input for the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sample accepted while the previous one is still in work");

   // no alert without a full window
   a_alert_needs_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_alert || rsp_window_full))
      else $error("alert raised on a beat without a full window");

   // count steps by exactly the alert bit, or stays saturated
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_alert_count == last_count_ff + COUNT_W'(rsp_alert))
                     || (rsp_alert && (last_count_ff == {COUNT_W{1'b1}})
                         && (rsp_alert_count == {COUNT_W{1'b1}}))))
      else $error("alert count does not follow the alert bits");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_window_full)
                                    && $stable(rsp_alert) && $stable(rsp_alert_count)))
      else $error("stalled result beat changed");

endmodule

bind sliding_median_spike_detector_core smsd_checker u_smsd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_window_full(rsp_window_full),
   .rsp_alert      (rsp_alert),
   .rsp_alert_count(rsp_alert_count)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for sliding_median_spike_detector_core: samples and window_length writes
// go in, a scoreboard class predicts every result beat; depends on smsd_pkg and the core rtl

module tb_top;

   localparam int unsigned WINDOW_CAP    = smsd_pkg::MAX_WINDOW_DEFAULT;
   localparam int unsigned SAMPLE_W      = smsd_pkg::SAMPLE_WIDTH_DEFAULT;
   localparam logic        REG_SPARE     = 1'b1;              // index with no register behind it
   localparam int unsigned SETTLE_CYCLES = 2 * WINDOW_CAP + 8; // comfortably above one full-window item
   localparam int unsigned QUIET_LIMIT   = 5000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SEG_ITEMS     = 62;

   // window settings walked by the random part, extremes included
   localparam logic [smsd_pkg::WL_W-1:0] WINDOW_PLAN [12] = '{
      6'd5, 6'd1, 6'd0, 6'd2, 6'd3, 6'd4, 6'd7, 6'd16, 6'd31, 6'd32, 6'd33, 6'd63};
   // field extremes to open the directed part
   localparam logic [SAMPLE_W-1:0] OPENING [5] = '{16'h0000, 16'hFFFF, 16'h0001,
                                                   16'h8000, 16'h7FFF};

   // predicts window_full, alert and the alert count for every accepted sample
   class median_scoreboard;
      typedef struct packed {
         logic                         full;
         logic                         alert;
         logic [smsd_pkg::COUNT_W-1:0] count;
      } verdict_type;

      logic [SAMPLE_W-1:0]          history [WINDOW_CAP];
      int unsigned                  wr_ptr;
      int unsigned                  filled;
      logic [smsd_pkg::COUNT_W-1:0] alert_total;
      logic [smsd_pkg::WL_W-1:0]    window_reg;
      verdict_type                  expected_q [$];
      int unsigned                  errors;
      int unsigned                  results_seen;
      int unsigned                  alerts_seen;
      int unsigned                  full_seen;

      function new();
         foreach (history[i]) history[i] = '0;
         wr_ptr       = 0;
         filled       = 0;
         alert_total  = '0;
         window_reg   = smsd_pkg::WINDOW_RESET;
         errors       = 0;
         results_seen = 0;
         alerts_seen  = 0;
         full_seen    = 0;
      endfunction

      function void report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endfunction

      // length actually in force: 0 acts as 1, anything past the cap as the cap
      function int unsigned span();
         if (window_reg == '0) begin
            return 1;
         end
         if (window_reg > WINDOW_CAP) begin
            return WINDOW_CAP;
         end
         return window_reg;
      endfunction

      function bit ready();
         return filled >= span();
      endfunction

      // twice the median of the trailing window, or the sum of both middles when even
      function logic [SAMPLE_W:0] threshold();
         logic [SAMPLE_W-1:0] w [WINDOW_CAP];
         logic [SAMPLE_W-1:0] v;
         int unsigned         len;
         int unsigned         pos;
         int unsigned         j;
         len = span();
         pos = wr_ptr;
         for (int unsigned i = 0; i < len; i++) begin
            pos  = (pos + WINDOW_CAP - 1) % WINDOW_CAP;
            w[i] = history[pos];
         end
         for (int unsigned i = 1; i < len; i++) begin
            v = w[i];
            j = i;
            while (j > 0 && w[j-1] > v) begin
               w[j] = w[j-1];
               j--;
            end
            w[j] = v;
         end
         if (len % 2 == 1) begin
            return {w[len/2], 1'b0};
         end
         return {1'b0, w[len/2-1]} + {1'b0, w[len/2]};
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] value);
         verdict_type v;
         v.full  = ready();
         v.alert = v.full && ({1'b0, value} >= threshold());
         if (v.alert && alert_total != '1) begin
            alert_total++;
         end
         v.count         = alert_total;
         history[wr_ptr] = value;
         wr_ptr          = (wr_ptr + 1) % WINDOW_CAP;
         if (filled < WINDOW_CAP) begin
            filled++;
         end
         expected_q.push_back(v);
      endfunction

      function void check_result(logic full, logic alert,
                                 logic [smsd_pkg::COUNT_W-1:0] count);
         verdict_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing outstanding (full %b alert %b count %0d)",
                             full, alert, count));
            return;
         end
         want = expected_q.pop_front();
         if (full !== want.full) begin
            report($sformatf("window_full %b, predicted %b", full, want.full));
         end
         if (alert !== want.alert) begin
            report($sformatf("alert %b, predicted %b", alert, want.alert));
         end
         if (count !== want.count) begin
            report($sformatf("alert_count %0d, predicted %0d", count, want.count));
         end
         if (want.full) begin
            full_seen++;
         end
         if (want.alert) begin
            alerts_seen++;
         end
      endfunction
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_valid  = 1'b0;
   logic                            req_stall;
   logic [SAMPLE_W-1:0]             req_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_stall  = 1'b0;
   logic                            rsp_window_full;
   logic                            rsp_alert;
   logic [smsd_pkg::COUNT_W-1:0]    rsp_alert_count;
   logic                            psel       = 1'b0;
   logic                            penable    = 1'b0;
   logic                            pwrite     = 1'b0;
   logic [smsd_pkg::APB_ADDR_W-1:0] paddr      = '0;
   logic [smsd_pkg::APB_DATA_W-1:0] pwdata     = '0;
   logic [smsd_pkg::APB_DATA_W-1:0] prdata;
   logic                            pready;

   median_scoreboard sb = new();

   // idle rates in percent per cycle, changed per phase by the main sequence
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   // long receiver hold-off, requested by the main sequence, counted by the receiver
   bit          hold_off_req  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned samples_sent  = 0;
   int unsigned windows_tried = 0;

   sliding_median_spike_detector_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_full(rsp_window_full),
      .rsp_alert      (rsp_alert),
      .rsp_alert_count(rsp_alert_count),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #5 clock = ~clock;

   // receiver: random stall per cycle, or a long counted hold-off on request
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // every result beat goes to the scoreboard, sampled before this edge's updates
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_window_full, rsp_alert, rsp_alert_count);
      end
   end

   // watchdog: too long without any beat on any port ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sb.expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one sample beat; valid stays up after acceptance unless the next call idles
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_sample(value);
      samples_sent++;
   endtask

   // sender pause: drop valid, wait for every result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write, setup then access; waits after the access with the bus released, for a clean bus
   task automatic csr_write(input logic index,
                            input logic [smsd_pkg::APB_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (index == smsd_pkg::REG_WINDOW_LENGTH) begin
         sb.window_reg = data[smsd_pkg::WL_W-1:0];
      end
   endtask

   // read window_length back and compare with the predicted register
   task automatic csr_check_window();
      logic [smsd_pkg::APB_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {smsd_pkg::REG_WINDOW_LENGTH, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got      = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got[smsd_pkg::WL_W-1:0] !== sb.window_reg) begin
         sb.report($sformatf("window_length reads %0d, predicted %0d",
                             got[smsd_pkg::WL_W-1:0], sb.window_reg));
      end
   endtask

   // new length with random junk in the unused data bits
   task automatic set_window(input logic [smsd_pkg::WL_W-1:0] len);
      drain();
      csr_write(smsd_pkg::REG_WINDOW_LENGTH,
                ($urandom & ~32'h3F) | smsd_pkg::APB_DATA_W'(len));
      csr_check_window();
      windows_tried++;
   endtask

   // sample placed relative to the current threshold, clamped to the field
   function automatic logic [SAMPLE_W-1:0] near_threshold(input int offset);
      int v;
      if (!sb.ready()) begin
         return SAMPLE_W'($urandom);
      end
      v = int'(sb.threshold()) + offset;
      if (v < 0) begin
         v = 0;
      end
      if (v > 65535) begin
         v = 65535;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // mostly a noisy baseline, with spikes, exact and just-missed thresholds, extremes
   function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned base);
      int unsigned roll;
      int          v;
      roll = $urandom_range(99);
      if (roll < 8) begin
         return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      end
      if (roll < 18) begin
         return SAMPLE_W'($urandom);
      end
      if (sb.ready() && roll < 32) begin
         return near_threshold(0);
      end
      if (sb.ready() && roll < 42) begin
         return near_threshold(-1);
      end
      if (sb.ready() && roll < 55) begin
         return near_threshold(int'($urandom_range(1, 20000)));
      end
      v = int'(base) + int'($urandom_range(0, base / 2 + 4)) - int'(base / 4);
      if (v < 0) begin
         v = 0;
      end
      if (v > 65535) begin
         v = 65535;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   initial begin
      int unsigned base;

      // synchronous reset held, then released on an edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset value of the register, field extremes while the window fills
      csr_check_window();
      foreach (OPENING[i]) begin
         send_sample(OPENING[i]);
      end
      // first full window: exact threshold alerts, one below does not
      send_sample(near_threshold(0));
      send_sample(near_threshold(-1));
      send_sample(16'hFFFF);

      // length 0 acts as 1, so a zero sample right after a zero alerts
      set_window(6'd0);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(near_threshold(-1));

      // even window compares against the sum of both middles
      set_window(6'd2);
      send_sample(near_threshold(0));
      send_sample(near_threshold(-1));
      send_sample(16'h8000);

      // a write to an index with no register is dropped, length must read back unchanged
      drain();
      csr_write(REG_SPARE, $urandom);
      csr_check_window();

      // growing the window past the history seen so far leaves it short of full again
      set_window(6'd32);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h1234);
      send_sample(16'hEDCB);

      // random part: one segment per window setting, idling phases across segments
      for (int unsigned seg = 0; seg < 12; seg++) begin
         set_window(WINDOW_PLAN[seg]);
         send_idle_pct = (seg < 4) ? 9 : (seg < 8) ? 87 : 0;
         recv_idle_pct = (seg < 4) ? 87 : (seg < 8) ? 9 : 0;
         // receiver holds off while the sender keeps offering, so the block backs up
         if (seg == 9) begin
            hold_off_req = 1'b1;
         end
         case ($urandom_range(2))
            0: begin
               base = $urandom_range(0, 15);
            end
            1: begin
               base = $urandom_range(100, 3000);
            end
            default: begin
               base = $urandom_range(8000, 30000);
            end
         endcase
         for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
            send_sample(pick_sample(base));
         end
      end

      // everything in flight must come back before the verdict
      drain();

      $display("run: %0d samples, %0d results checked, %0d judged on a full window, %0d alerts",
               samples_sent, sb.results_seen, sb.full_seen, sb.alerts_seen);
      $display("run: %0d window_length writes from 0 to 63, both sides idling, %0d-cycle hold",
               windows_tried, HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
